// ===== rtl/core/asf_pkg.sv =====
package asf_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W = 4;
  localparam int SAMPLE_W = 24;
  localparam int INT_W = 17;
  localparam int SCALE_W = 17;
  localparam int CFG_W = 17;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD1_W = DIFF_W + INT_W;
  localparam int RND1_W = PROD1_W - 12;
  localparam int T_W = RND1_W + 1;
  localparam int PROD2_W = T_W + SCALE_W + 1;
  localparam int WIDE_W = 34;

  localparam logic signed [WIDE_W-1:0] WIDE_SMAX = WIDE_W'(8388607);
  localparam logic signed [WIDE_W-1:0] WIDE_SMIN = WIDE_W'(-8388608);
  localparam logic signed [WIDE_W-1:0] WIDE_ONE = WIDE_W'(1048576);
  localparam logic signed [WIDE_W-1:0] WIDE_MONE = WIDE_W'(-1048576);

  typedef enum logic [1:0] {
    REG_INTENSITY = 2'd0,
    REG_SCALE     = 2'd1,
    REG_CLIP      = 2'd2,
    REG_ACTIVE    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_LOAD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [INT_W-1:0]    mult;
    logic                       smooth;
    logic                       chan_ok;
  } task_t;

  typedef struct packed {
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] sample;
  } res_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] r;
    if (v > WIDE_SMAX) begin
      r = WIDE_SMAX;
    end else if (v < WIDE_SMIN) begin
      r = WIDE_SMIN;
    end else begin
      r = v;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_one(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] r;
    if (v > WIDE_ONE) begin
      r = WIDE_ONE;
    end else if (v < WIDE_MONE) begin
      r = WIDE_MONE;
    end else begin
      r = v;
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/asf_front.sv =====
module asf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [asf_pkg::CH_W-1:0]            channel,
  input  logic signed [asf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [asf_pkg::INT_W-1:0]    intensity,
  input  logic                                active,
  output logic                                task_valid,
  input  logic                                task_take,
  output asf_pkg::task_t                      task_out
);
  import asf_pkg::*;

  task_t      q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  task_t      incoming;
  logic       do_push;
  logic       do_pop;

  // Classify at entry: inactive means zero strength, sign picks the mode
  always_comb begin
    incoming.ch      = channel;
    incoming.x       = sample_in;
    incoming.mult    = active ? intensity : '0;
    incoming.smooth  = active & intensity[INT_W-1];
    incoming.chan_ok = (32'(channel) < MAX_CHANNELS);
  end

  assign full       = (count == 2'd2);
  assign task_valid = (count != 2'd0);
  assign task_out   = q[rptr];
  assign do_push    = push & ~full;
  assign do_pop     = task_take & task_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= incoming;
    end
  end

endmodule

// ===== rtl/core/asf_back.sv =====
module asf_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               task_valid,
  output logic                               task_take,
  input  asf_pkg::task_t                     task_in,
  input  logic [asf_pkg::SCALE_W-1:0]        smoothing_scale,
  input  logic                               clip_enable,
  output logic                               res_valid,
  input  logic                               res_ready,
  output asf_pkg::res_t                      res
);
  import asf_pkg::*;

  state_t                      st;
  state_t                      st_next;
  task_t                       cur;
  logic signed [PROD1_W-1:0]   p1;
  logic signed [PROD1_W-1:0]   p1_next;
  logic signed [SAMPLE_W-1:0]  mem [2**CH_W];

  logic signed [SAMPLE_W-1:0]  prev;
  logic signed [DIFF_W-1:0]    opnd;
  logic signed [PROD1_W-1:0]   rsum;
  logic signed [RND1_W-1:0]    r1;
  logic signed [T_W-1:0]       t;
  logic signed [SCALE_W:0]     scale_s;
  logic signed [PROD2_W-1:0]   p2;
  logic signed [PROD2_W-1:0]   p2r;
  logic signed [WIDE_W-1:0]    y;
  logic signed [SAMPLE_W-1:0]  store_val;
  logic                        finish;

  // Load state: fetch the channel history and form the strength product
  always_comb begin
    prev = task_in.chan_ok ? mem[task_in.ch] : '0;
    if (task_in.smooth) begin
      opnd = DIFF_W'(prev);
    end else begin
      opnd = DIFF_W'(task_in.x) - DIFF_W'(prev);
    end
    p1_next = PROD1_W'(opnd) * PROD1_W'(task_in.mult);
  end

  // Finish state: round; smoothing mode scales, sharpen mode adds the sample
  always_comb begin
    rsum    = p1 + PROD1_W'(2048);
    r1      = $signed(rsum[PROD1_W-1:12]);
    t       = T_W'(cur.x) - T_W'(r1);
    scale_s = $signed({1'b0, smoothing_scale});
    p2      = PROD2_W'(t) * PROD2_W'(scale_s);
    p2r     = p2 + PROD2_W'(32768);
    if (cur.smooth) begin
      y         = WIDE_W'($signed(p2r[PROD2_W-1:16]));
      store_val = sat_sample(y);
    end else begin
      y         = WIDE_W'(cur.x) + WIDE_W'(r1);
      store_val = cur.x;
    end
    res.ch     = cur.ch;
    res.sample = clip_enable ? clamp_one(y) : sat_sample(y);
  end

  always_comb begin
    st_next   = st;
    task_take = 1'b0;
    res_valid = 1'b0;
    finish    = 1'b0;
    unique case (st)
      ST_LOAD: begin
        task_take = task_valid;
        if (task_valid) begin
          st_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          finish  = 1'b1;
          st_next = ST_LOAD;
        end
      end
      default: st_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_LOAD;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (task_take) begin
      cur <= task_in;
      p1  <= p1_next;
    end
  end

  // History is written as the result leaves, so the next fetch sees it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2**CH_W; i++) begin
        mem[i] <= '0;
      end
    end else if (finish && cur.chan_ok) begin
      mem[cur.ch] <= store_val;
    end
  end

endmodule

// ===== rtl/core/asf_outq.sv =====
module asf_outq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 res_valid,
  output logic                                 res_ready,
  input  asf_pkg::res_t                        res,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [asf_pkg::CH_W-1:0]             channel_out,
  output logic signed [asf_pkg::SAMPLE_W-1:0]  sample_out
);
  import asf_pkg::*;

  res_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_ready   = (count != 2'd2);
  assign empty       = (count == 2'd0);
  assign do_push     = res_valid & res_ready;
  assign do_pop      = pop & ~empty;
  assign channel_out = q[rptr].ch;
  assign sample_out  = q[rptr].sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= res;
    end
  end

endmodule

// ===== rtl/core/audio_sharpen_smooth_filter.sv =====
// Per-channel first-order sharpen/smooth filter on Q3.20 samples.
//
// Input channel: a queue write port. An item (channel, sample_in) is taken
// at a clock edge with push high and full low. Results: a queue read port.
// While empty is low the oldest result sits on channel_out/sample_out and
// is taken at an edge with pop high. Every item gives exactly one result.
//
// The execute unit fetches the channel history and multiplies by the
// strength in its load state, then rounds, scales and writes the history
// back in its finish state; it takes no new item until its result has
// left for the output queue. Two-entry queues sit before and after the
// execute unit, so up to five items can be in flight; full rises when
// the input queue fills, and a stalled reader holds the execute unit
// once the output queue is full.
//
// Reset (rst, synchronous) empties both queues, clears every channel's
// history and loads register defaults. The user writes registers through
// cfg_write/cfg_index/cfg_data only while no item is in flight; unenforced.
module audio_sharpen_smooth_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [asf_pkg::CH_W-1:0]             channel,
  input  logic signed [asf_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [asf_pkg::CH_W-1:0]             channel_out,
  output logic signed [asf_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                                 cfg_write,
  input  logic [1:0]                           cfg_index,
  input  logic [asf_pkg::CFG_W-1:0]            cfg_data
);
  import asf_pkg::*;

  logic signed [INT_W-1:0] intensity;
  logic [SCALE_W-1:0]      smoothing_scale;
  logic                    clip_enable;
  logic                    active;

  logic  task_valid;
  logic  task_take;
  task_t task_bus;
  logic  res_valid;
  logic  res_ready;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity       <= INT_W'(8192);
      smoothing_scale <= SCALE_W'(65536);
      clip_enable     <= 1'b1;
      active          <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INTENSITY: intensity <= $signed(cfg_data[INT_W-1:0]);
        REG_SCALE:     smoothing_scale <= cfg_data[SCALE_W-1:0];
        REG_CLIP:      clip_enable <= cfg_data[0];
        REG_ACTIVE:    active <= cfg_data[0];
        default: ;
      endcase
    end
  end

  asf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .channel    (channel),
    .sample_in  (sample_in),
    .intensity  (intensity),
    .active     (active),
    .task_valid (task_valid),
    .task_take  (task_take),
    .task_out   (task_bus)
  );

  asf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .task_valid      (task_valid),
    .task_take       (task_take),
    .task_in         (task_bus),
    .smoothing_scale (smoothing_scale),
    .clip_enable     (clip_enable),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  asf_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .empty       (empty),
    .pop         (pop),
    .channel_out (channel_out),
    .sample_out  (sample_out)
  );

endmodule

// ===== rtl/core/asf_check.sv =====
module asf_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 push,
  input logic                                 full,
  input logic                                 empty,
  input logic                                 pop,
  input logic [asf_pkg::CH_W-1:0]             channel_out,
  input logic signed [asf_pkg::SAMPLE_W-1:0]  sample_out
);
  import asf_pkg::*;

  logic [2:0] inflight;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = push & ~full;
  assign acc_out = pop & ~empty;

  // Track items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight + 3'(acc_in) - 3'(acc_out);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results visible after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (inflight == 3'd0) |-> empty)
    else $error("result shown with no item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd5)
    else $error("more items in flight than the queues hold");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (inflight == 3'd0 && acc_in) |-> ##3 !empty)
    else $error("lone item did not reach the output in three cycles");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(channel_out) && $stable(sample_out)))
    else $error("waiting result changed");

endmodule

bind audio_sharpen_smooth_filter asf_check u_check (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .channel_out (channel_out),
  .sample_out  (sample_out)
);
